>>> src/igmp_pkg.sv
// Package for the IGMP packet builder: request/result types, datagram type,
// header constants and the ones'-complement fold. No dependencies.
package igmp_pkg;

    localparam int WORD_COUNT = 7;
    localparam int IDX_W      = $clog2(WORD_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_COUNT - 1);

    localparam logic [31:0] IPV4_VER_IHL_TOS_LEN = 32'h4500_001C;
    localparam logic [15:0] IPV4_TTL_PROTO       = 16'h0102;
    localparam logic [31:0] ALL_HOSTS_ADDR       = 32'hE000_0001;
    localparam logic [31:0] ALL_ROUTERS_ADDR     = 32'hE000_0002;
    localparam logic [7:0]  TYPE_QUERY           = 8'h11;
    localparam logic [7:0]  TYPE_LEAVE           = 8'h17;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [7:0]  max_resp_time;
        logic [31:0] group_addr;
        logic        group_given;
        logic [31:0] source_addr;
        logic [15:0] packet_id;
    } igmp_req_t;

    typedef struct packed {
        logic [31:0]      word;
        logic [IDX_W-1:0] word_index;
        logic             last;
    } igmp_res_t;

    // word 0 in the low slot
    typedef logic [WORD_COUNT-1:0][31:0] datagram_t;

    // Fold a sum of up to sixteen 16-bit halves and complement it.
    function automatic logic [15:0] csum_finish(input logic [19:0] acc);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, acc[15:0]} + {13'd0, acc[19:16]};
        s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
        return ~s2[15:0];
    endfunction

endpackage

>>> src/igmp_build.sv
// Combinational datagram builder: IPv4 header, IGMP message, both checksums.
// Depends on igmp_pkg.
module igmp_build (
    input  igmp_pkg::igmp_req_t req,
    output igmp_pkg::datagram_t words
);
    import igmp_pkg::*;

    logic [31:0] group;
    logic [31:0] dst;
    logic [19:0] ip_acc;
    logic [19:0] igmp_acc;
    logic [15:0] ip_csum;
    logic [15:0] igmp_csum;

    always_comb
    begin
        group = req.group_given ? req.group_addr : 32'd0;
        if (req.msg_type == TYPE_QUERY)
        begin
            dst = req.group_given ? group : ALL_HOSTS_ADDR;
        end
        else if (req.msg_type == TYPE_LEAVE)
        begin
            dst = ALL_ROUTERS_ADDR;
        end
        else
        begin
            dst = group;
        end

        ip_acc = 20'(IPV4_VER_IHL_TOS_LEN[31:16]) + 20'(IPV4_VER_IHL_TOS_LEN[15:0])
               + 20'(req.packet_id) + 20'(IPV4_TTL_PROTO)
               + 20'(req.source_addr[31:16]) + 20'(req.source_addr[15:0])
               + 20'(dst[31:16]) + 20'(dst[15:0]);
        ip_csum = csum_finish(ip_acc);

        igmp_acc = 20'({req.msg_type, req.max_resp_time})
                 + 20'(group[31:16]) + 20'(group[15:0]);
        igmp_csum = csum_finish(igmp_acc);

        words[0] = IPV4_VER_IHL_TOS_LEN;
        words[1] = {req.packet_id, 16'd0};
        words[2] = {IPV4_TTL_PROTO, ip_csum};
        words[3] = req.source_addr;
        words[4] = dst;
        words[5] = {req.msg_type, req.max_resp_time, igmp_csum};
        words[6] = group;
    end

endmodule

>>> src/igmp_ser.sv
// Result register and word serializer: holds one datagram, shifts out a word
// per taken result. Depends on igmp_pkg.
module igmp_ser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    input  igmp_pkg::datagram_t load_words,
    output logic                ready,
    output logic                res_valid,
    input  logic                res_stall,
    output igmp_pkg::igmp_res_t res
);
    import igmp_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    datagram_t        words_reg;
    datagram_t        words_next;
    logic             take;
    logic             last_take;
    logic             load;

    assign take      = busy_reg & ~res_stall;
    assign last_take = take & (idx_reg == LAST_IDX);
    assign ready     = ~busy_reg | last_take;
    assign load      = load_valid & ready;

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        words_next = words_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            idx_next   = '0;
            words_next = load_words;
        end
        else if (take)
        begin
            busy_next  = ~last_take;
            idx_next   = idx_reg + 1'b1;
            words_next = {32'd0, words_reg[WORD_COUNT-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

    assign res_valid      = busy_reg;
    assign res.word       = words_reg[0];
    assign res.word_index = idx_reg;
    assign res.last       = (idx_reg == LAST_IDX);

endmodule

>>> src/igmp_packet_builder_top.sv
// IGMPv2 packet builder: one request in, a 28-byte IPv4+IGMP datagram out as
// seven 32-bit network-order words. The accepted request passes the request
// register, then the result register, before the first word is valid; this
// takes longer while an earlier datagram still drains. The seven-word output
// port sets the request rate; a new request is parked while one drains.
// Reset: rst_n async active low clears the valid flags; no payload is reset.
module igmp_packet_builder_top (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  igmp_pkg::igmp_req_t req,
    // result channel, one word per transfer
    output logic                res_valid,
    input  logic                res_stall,
    output igmp_pkg::igmp_res_t res
);
    import igmp_pkg::*;

    // Request register: holds one request while the serializer drains the
    // previous datagram, so a new request is taken while results still wait.
    logic      req_vld_reg;
    logic      req_vld_next;
    igmp_req_t req_reg;
    logic      req_accept;
    logic      ser_ready;
    datagram_t dgram;

    // Stall only when a request is parked and the serializer cannot take it.
    assign req_stall  = req_vld_reg & ~ser_ready;
    assign req_accept = req_valid & ~req_stall;

    always_comb
    begin
        req_vld_next = req_vld_reg;
        if (req_accept)
        begin
            req_vld_next = 1'b1;
        end
        else if (ser_ready)
        begin
            // parked request (if any) moved into the serializer
            req_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_reg <= req;
        end
    end

    // Header fields, destination select and both checksums in one pass.
    igmp_build u_build (
        .req   (req_reg),
        .words (dgram)
    );

    // Result register; the last word taken frees it for the next datagram
    // in the same cycle.
    igmp_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (req_vld_reg),
        .load_words (dgram),
        .ready      (ser_ready),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule
